>>> sv/b2d_pkg.sv
// Shared constants for the binary to decimal ASCII converter.
// No dependencies; the interfaces and the top level import it.
package b2d_pkg;

  // Fixed field widths of the channels.
  localparam int VALUE_BITS   = 64;
  localparam int CHAR_BITS    = 6;

  // Default parameter values.
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int MAX_DIGITS_DEF  = 20;

  // Upper two bits of ASCII '0' through '9' after masking to six bits.
  localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;

  // Digit threshold and correction of the shift-add-3 step.
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

endpackage

>>> sv/b2d_if.sv
// Valid/ready channel interfaces for the input value and the output digits.
// Depends on b2d_pkg for the field widths.
interface b2d_in_if;
  import b2d_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2d_out_if;
  import b2d_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] digit_char;
  logic                 last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

>>> sv/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter. The shift-add-3 conversion takes one input
// bit per cycle; then the leading zeros are dropped and the digits are loaded,
// one per cycle while the receiver takes them, into the output register. A new
// value is accepted only in idle, after the last digit of the previous one has
// been loaded. Receiver stalls hold up the digit output.
// Reset (rst, synchronous) returns to idle and drops any pending output digit.
module binary_to_decimal_ascii #(
  parameter int VALUE_WIDTH = b2d_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = b2d_pkg::MAX_DIGITS_DEF
) (
  input logic         clk,
  input logic         rst,
  b2d_in_if.sink      in_ch,
  b2d_out_if.source   out_ch
);
  import b2d_pkg::*;

  localparam int BCD_BITS = 4 * MAX_DIGITS;
  localparam int BCNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int DCNT_W   = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] bin;
  logic [BCD_BITS-1:0]    bcd;
  logic [BCD_BITS-1:0]    bcd_adj;
  logic                   ovf;
  logic [BCNT_W-1:0]      bcnt;
  logic [DCNT_W-1:0]      dcnt;
  logic                   out_valid;
  logic [3:0]             out_digit;
  logic                   out_last;
  logic [3:0]             top_digit;
  logic                   out_free;

  // Add 3 to every BCD digit of 5 or more before the next left shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= BCD_ADJ_MIN) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + BCD_ADJ;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign top_digit = bcd[BCD_BITS-1 -: 4];
  assign out_free  = !out_valid || out_ch.ready;

  // Handshake and payload outputs.
  assign in_ch.ready       = (state == ST_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.digit_char = {ASCII_DIGIT_HI, out_digit};
  assign out_ch.last_digit = out_last;

  // Sequencer: load, convert bit by bit, drop leading zeros, emit digits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In the emit state the output register is reloaded below instead.
      if (out_valid && out_ch.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            bin   <= in_ch.value[VALUE_WIDTH-1:0];
            bcd   <= '0;
            ovf   <= 1'b0;
            bcnt  <= BCNT_W'(VALUE_WIDTH);
            dcnt  <= DCNT_W'(MAX_DIGITS);
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          // A one shifted out of the top digit means the number has more
          // digits than fit; then every kept digit is emitted.
          ovf  <= ovf | bcd_adj[BCD_BITS-1];
          bcd  <= {bcd_adj[BCD_BITS-2:0], bin[VALUE_WIDTH-1]};
          bin  <= {bin[VALUE_WIDTH-2:0], 1'b0};
          bcnt <= bcnt - 1'b1;
          if (bcnt == BCNT_W'(1)) begin
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // Drop leading zeros, always keeping the final digit.
          if (!ovf && top_digit == 4'd0 && dcnt != DCNT_W'(1)) begin
            bcd  <= {bcd[BCD_BITS-5:0], 4'd0};
            dcnt <= dcnt - 1'b1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_digit <= top_digit;
            out_last  <= (dcnt == DCNT_W'(1));
            bcd       <= {bcd[BCD_BITS-5:0], 4'd0};
            dcnt      <= dcnt - 1'b1;
            if (dcnt == DCNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> verif/binary_to_decimal_ascii_test.sv
// Self-checking testbench for binary_to_decimal_ascii: feeds 64-bit values and checks
// each digit character and the last-digit mark against a decimal conversion done here.
// Depends on b2d_pkg, the b2d_in_if/b2d_out_if interfaces and the converter RTL.
module binary_to_decimal_ascii_test;
  import b2d_pkg::*;

  // Block configuration under test, and the matching view of it used for prediction.
  localparam int CONV_WIDTH  = VALUE_WIDTH_DEF;
  localparam int DIGIT_LIMIT = (MAX_DIGITS_DEF > 20) ? 20 : MAX_DIGITS_DEF;
  localparam logic [VALUE_BITS-1:0] CONV_MASK =
    (CONV_WIDTH >= 64) ? '1 : ((64'd1 << CONV_WIDTH) - 64'd1);
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [VALUE_BITS-1:0] DECIMAL_BASE = 64'd10;

  // Receiver hold-off window, in cycles after reset, that backs up the block.
  localparam int HOLD_START = 2000;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last_digit;
  } digit_item_t;

  logic clk = 1'b0;
  logic rst;

  b2d_in_if  in_ch();
  b2d_out_if out_ch();

  binary_to_decimal_ascii #(
    .VALUE_WIDTH (CONV_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS_DEF)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [VALUE_BITS-1:0] pending_values[$];
  digit_item_t           expected_digits[$];
  int                    mismatches = 0;

  int send_burst_left;
  int send_gap_left;
  int recv_cycle;
  int recv_mode;

  // Clock with a 10 unit period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queue the expected digit characters of one value, most significant first.
  function automatic void queue_decimal_digits(input logic [VALUE_BITS-1:0] raw);
    logic [VALUE_BITS-1:0] rest;
    logic [3:0]            lsd_first[20];
    int                    count;
    digit_item_t           dig;
    rest  = raw & CONV_MASK;
    count = 0;
    do begin
      lsd_first[count] = 4'(rest % DECIMAL_BASE);
      count++;
      rest = rest / DECIMAL_BASE;
    end while (rest != 0 && count < DIGIT_LIMIT);
    for (int k = count - 1; k >= 0; k--) begin
      dig.digit_char = CHAR_BITS'(ASCII_ZERO + 8'(lsd_first[k]));
      dig.last_digit = (k == 0);
      expected_digits.push_back(dig);
    end
  endfunction

  // Sender: offers queued values in bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid     <= 1'b0;
      in_ch.value     <= '0;
      send_burst_left <= 0;
      send_gap_left   <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        queue_decimal_digits(in_ch.value);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap_left > 0) begin
          send_gap_left <= send_gap_left - 1;
          in_ch.valid   <= 1'b0;
        end else if (pending_values.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.value <= pending_values.pop_front();
          if (send_burst_left <= 1) begin
            send_burst_left <= $urandom_range(1, 8);
            send_gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
          end else begin
            send_burst_left <= send_burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every accepted digit item and stalls on a pattern of its own.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_cycle   <= 0;
      recv_mode    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected digit item char=%0d last=%0b", $time,
                   out_ch.digit_char, out_ch.last_digit);
          mismatches++;
        end else begin
          if (out_ch.digit_char !== expected_digits[0].digit_char) begin
            $display("%0t: digit_char expected %0d actual %0d", $time,
                     expected_digits[0].digit_char, out_ch.digit_char);
            mismatches++;
          end
          if (out_ch.last_digit !== expected_digits[0].last_digit) begin
            $display("%0t: last_digit expected %0b actual %0b", $time,
                     expected_digits[0].last_digit, out_ch.last_digit);
            mismatches++;
          end
          void'(expected_digits.pop_front());
        end
      end

      recv_cycle <= recv_cycle + 1;
      // Pick a new stall pattern whenever recv_cycle is a multiple of 512.
      if (recv_cycle % 512 == 0) begin
        recv_mode <= $urandom_range(0, 2);
      end
      // One long hold-off so that the block fills up and refuses input.
      if (recv_cycle >= HOLD_START && recv_cycle < HOLD_START + HOLD_LEN) begin
        out_ch.ready <= 1'b0;
      end else if (recv_mode == 0) begin
        out_ch.ready <= 1'b1;
      end else if (recv_mode == 1) begin
        out_ch.ready <= 1'($urandom_range(0, 1));
      end else begin
        out_ch.ready <= ($urandom_range(0, 7) == 0);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [VALUE_BITS-1:0] power_of_ten[20];
    logic [VALUE_BITS-1:0] pick;
    int                    decade;

    rst = 1'b1;

    // Directed values: zero, digit-count boundaries, full width and bit patterns.
    pending_values.push_back(64'd0);
    pending_values.push_back(64'd1);
    pending_values.push_back(64'd9);
    pending_values.push_back(64'd10);
    pending_values.push_back(64'd99);
    pending_values.push_back(64'd100);
    pending_values.push_back(64'd999999999);
    pending_values.push_back(64'd1000000000);
    pending_values.push_back(64'd4294967295);
    pending_values.push_back(64'd4294967296);
    pending_values.push_back(64'd9999999999999999999);
    pending_values.push_back(64'd10000000000000000000);
    pending_values.push_back(64'd12345678901234567890);
    pending_values.push_back(64'h8000_0000_0000_0000);
    pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_values.push_back(64'h5555_5555_5555_5555);
    pending_values.push_back(64'h0123_4567_89AB_CDEF);
    pending_values.push_back(64'd0);

    power_of_ten[0] = 64'd1;
    for (int k = 1; k < 20; k++) begin
      power_of_ten[k] = power_of_ten[k-1] * DECIMAL_BASE;
    end

    // Random values spread over all magnitudes, some close to powers of ten.
    for (int n = 0; n < 200; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        decade = $urandom_range(0, 19);
        pick   = power_of_ten[decade] + 64'($urandom_range(0, 2)) - 64'd1;
      end else begin
        pick = {$urandom, $urandom} >> $urandom_range(0, 63);
      end
      pending_values.push_back(pick);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_values.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
sv/b2d_pkg.sv
sv/b2d_if.sv
sv/binary_to_decimal_ascii.sv
verif/binary_to_decimal_ascii_test.sv
